// File: rtl/core/summed_area_table_2d_macros.svh
// Assertion macros shared by the summed-area table RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SUMMED_AREA_TABLE_2D_MACROS_SVH
`define SUMMED_AREA_TABLE_2D_MACROS_SVH

`ifndef ASSERT_OFF

`define SAT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("summed_area_table_2d: assertion failed");

`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("summed_area_table_2d: assertion failed");

`else

`define SAT_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SAT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/sat_pkg.sv
// Types, codes and the microcode table of the summed-area table engine.
// Used by sat_useq and summed_area_table_2d; depends on nothing else.
`default_nettype none

package sat_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [6:0]         x_start;
    logic [6:0]         y_start;
    logic [6:0]         x_end;
    logic [6:0]         y_end;
    logic signed [31:0] value;
  } in_item_t;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] sum;
  } out_item_t;

  localparam int CFG_DATA_W = 7;

  typedef enum logic {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET = 7'd64;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_CLR_INIT = 4'd0;
  localparam upc_t UPC_CLR_LOOP = 4'd1;
  localparam upc_t UPC_IDLE     = 4'd2;
  localparam upc_t UPC_ADD0     = 4'd3;
  localparam upc_t UPC_ADD1     = 4'd4;
  localparam upc_t UPC_QRY0     = 4'd5;
  localparam upc_t UPC_QRY1     = 4'd6;
  localparam upc_t UPC_QRY2     = 4'd7;
  localparam upc_t UPC_QRY3     = 4'd8;
  localparam upc_t UPC_QRY4     = 4'd9;
  localparam upc_t UPC_BLD0     = 4'd10;
  localparam upc_t UPC_BLD1     = 4'd11;
  localparam upc_t UPC_BLD2     = 4'd12;
  localparam upc_t UPC_BLD3     = 4'd13;
  localparam upc_t UPC_BLD4     = 4'd14;
  localparam upc_t UPC_BLD_DONE = 4'd15;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_DISPATCH,
    SEQ_LOOP,
    SEQ_EMIT
  } seq_t;

  typedef enum logic [1:0] {
    SEL_AA,
    SEL_AB,
    SEL_BA,
    SEL_BB
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_ACC
  } wr_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADDV
  } acc_op_t;

  typedef struct packed {
    seq_t      seq;
    upc_t      target;
    logic      rd;
    addr_sel_t rsel;
    wr_t       wr;
    acc_op_t   acc;
    logic      clr_init;
    logic      kind;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    upc_t entry;
    logic loop_end;
    logic out_free;
  } seq_stat_t;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t c;
    c = '{seq: SEQ_NEXT, target: UPC_IDLE, rd: 1'b0, rsel: SEL_AA, wr: WR_NONE,
          acc: ACC_HOLD, clr_init: 1'b0, kind: KIND_BUILD};
    unique case (pc)
      UPC_CLR_INIT: begin
        c.clr_init = 1'b1;
      end
      UPC_CLR_LOOP: begin
        c.wr = WR_ZERO;
        c.seq = SEQ_LOOP;
        c.target = UPC_CLR_LOOP;
      end
      UPC_IDLE: begin
        c.seq = SEQ_DISPATCH;
      end
      UPC_ADD0: begin
        c.rd = 1'b1;
      end
      UPC_ADD1: begin
        c.acc = ACC_ADDV;
        c.wr = WR_ACC;
        c.seq = SEQ_JUMP;
      end
      UPC_QRY0: begin
        c.rd = 1'b1;
      end
      UPC_QRY1: begin
        c.rd = 1'b1;
        c.rsel = SEL_BA;
        c.acc = ACC_LOAD;
      end
      UPC_QRY2: begin
        c.rd = 1'b1;
        c.rsel = SEL_AB;
        c.acc = ACC_SUB;
      end
      UPC_QRY3: begin
        c.rd = 1'b1;
        c.rsel = SEL_BB;
        c.acc = ACC_SUB;
      end
      UPC_QRY4: begin
        c.acc = ACC_ADD;
        c.seq = SEQ_EMIT;
        c.kind = KIND_QUERY;
      end
      UPC_BLD0: begin
        c.rd = 1'b1;
      end
      UPC_BLD1: begin
        c.rd = 1'b1;
        c.rsel = SEL_AB;
        c.acc = ACC_LOAD;
      end
      UPC_BLD2: begin
        c.rd = 1'b1;
        c.rsel = SEL_BA;
        c.acc = ACC_ADD;
      end
      UPC_BLD3: begin
        c.rd = 1'b1;
        c.rsel = SEL_BB;
        c.acc = ACC_ADD;
      end
      UPC_BLD4: begin
        c.acc = ACC_SUB;
        c.wr = WR_ACC;
        c.seq = SEQ_LOOP;
        c.target = UPC_BLD0;
      end
      UPC_BLD_DONE: begin
        c.seq = SEQ_EMIT;
        c.kind = KIND_BUILD;
      end
      default: begin
        c.seq = SEQ_JUMP;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/sat_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
// Standalone; used by summed_area_table_2d.
`default_nettype none

module sat_ram #(
  parameter int DEPTH = 4225,
  parameter int AW    = 13,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sat_useq.sv
// Microcode sequencer: step counter, control-word table lookup and jump logic.
// Depends on sat_pkg for the control word, status struct and microcode table.
`default_nettype none

module sat_useq
  import sat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire seq_stat_t stat,
  output ctrl_t          cw
);

  upc_t pc;
  upc_t pc_next;

  assign cw = ucode(pc);

  always_comb begin
    unique case (cw.seq)
      SEQ_NEXT:     pc_next = pc + upc_t'(1);
      SEQ_JUMP:     pc_next = cw.target;
      SEQ_DISPATCH: pc_next = stat.in_fire ? stat.entry : pc;
      SEQ_LOOP:     pc_next = stat.loop_end ? pc + upc_t'(1) : cw.target;
      SEQ_EMIT:     pc_next = stat.out_free ? cw.target : pc;
      default:      pc_next = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= UPC_CLR_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/summed_area_table_2d.sv
// Summed-area table engine: top level with datapath, table memory and sequencer.
// Depends on sat_pkg, sat_ram, sat_useq and summed_area_table_2d_macros.svh.
//
// Items arrive on in_valid/in_ready with an in_item_t payload; results leave on
// out_valid/out_ready with an out_item_t payload. The cfg port writes the column
// and row counts with no handshake and may only be used while the block is idle.
// A microcoded sequencer runs each item over a table memory with one write and one
// read port, one table read or write per cycle, so the memory ports set the item time.
// An add reads its cell, adds the value and writes it back, or does nothing when
// its cell lies outside the region, and gives no result. A query reads four table
// cells and gives their combined sum as its result. A build takes five steps
// per cell, then posts a done result. The result sits in an output register, so
// the block returns to idle and takes the next transfer while the result waits;
// an item that produces a result stalls in its last step only while that register
// is full and out_ready is low.
// After reset the registers return to 64 and the table, guard cells included, is
// zeroed by a clearing pass during which in_ready stays low. Configuration writes
// are taken during that pass.
`default_nettype none
`include "summed_area_table_2d_macros.svh"

module summed_area_table_2d
  import sat_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64,
  parameter int SUM_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire cfg_idx_t              cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  localparam int STRIDE = MAX_ROWS + 1;
  localparam int DEPTH  = (MAX_COLS + 1) * STRIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int CX_W   = $clog2(MAX_COLS + 1);
  localparam int CY_W   = $clog2(MAX_ROWS + 1);

  ctrl_t     cw;
  seq_stat_t stat;

  logic [CFG_DATA_W-1:0] cols;
  logic [CFG_DATA_W-1:0] rows;
  logic [CX_W-1:0]       w_eff;
  logic [CY_W-1:0]       h_eff;

  logic [CX_W-1:0] xa;
  logic [CX_W-1:0] xb;
  logic [CY_W-1:0] ya;
  logic [CY_W-1:0] yb;
  logic [CX_W-1:0] lim_x;
  logic [CY_W-1:0] lim_y;
  logic            y_first;

  logic [CX_W-1:0] q_xs;
  logic [CX_W-1:0] q_xe;
  logic [CY_W-1:0] q_ys;
  logic [CY_W-1:0] q_ye;
  logic            add_ok;
  upc_t            entry;

  logic signed [31:0]  val;
  logic [SUM_BITS-1:0] acc;
  logic [SUM_BITS-1:0] acc_next;
  logic [SUM_BITS-1:0] rdata;
  logic [SUM_BITS-1:0] wdata;

  logic [CX_W-1:0] rx;
  logic [CY_W-1:0] ry;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            ram_we;

  logic in_fire;
  logic out_free;
  logic step_go;
  logic emit_go;
  logic loop_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= CFG_RESET;
      rows <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COLS: cols <= cfg_data;
        CFG_ROWS: rows <= cfg_data;
        default:  cols <= cols;
      endcase
    end
  end

  assign w_eff = (32'(cols) > 32'(MAX_COLS)) ? CX_W'(MAX_COLS) : CX_W'(cols);
  assign h_eff = (32'(rows) > 32'(MAX_ROWS)) ? CY_W'(MAX_ROWS) : CY_W'(rows);

  assign q_xs = (32'(in_data.x_start) > 32'(w_eff)) ? w_eff : CX_W'(in_data.x_start);
  assign q_xe = (32'(in_data.x_end) > 32'(w_eff)) ? w_eff : CX_W'(in_data.x_end);
  assign q_ys = (32'(in_data.y_start) > 32'(h_eff)) ? h_eff : CY_W'(in_data.y_start);
  assign q_ye = (32'(in_data.y_end) > 32'(h_eff)) ? h_eff : CY_W'(in_data.y_end);

  assign add_ok = (32'(in_data.x_start) < 32'(w_eff)) && (32'(in_data.y_start) < 32'(h_eff));

  always_comb begin
    case (in_data.op)
      OP_ADD:   entry = add_ok ? UPC_ADD0 : UPC_IDLE;
      OP_BUILD: entry = (w_eff != '0 && h_eff != '0) ? UPC_BLD0 : UPC_BLD_DONE;
      OP_QUERY: entry = UPC_QRY0;
      default:  entry = UPC_IDLE;
    endcase
  end

  assign in_ready = (cw.seq == SEQ_DISPATCH);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign step_go  = !(cw.seq == SEQ_EMIT && !out_free) && (cw.seq != SEQ_DISPATCH);
  assign emit_go  = (cw.seq == SEQ_EMIT) && out_free;
  assign loop_end = (xa == lim_x) && (ya == lim_y);

  assign stat = '{in_fire: in_fire, entry: entry, loop_end: loop_end, out_free: out_free};

  sat_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  always_ff @(posedge clk) begin
    if (cw.clr_init) begin
      xa      <= '0;
      xb      <= '0;
      ya      <= '0;
      yb      <= '0;
      y_first <= 1'b0;
      lim_x   <= CX_W'(MAX_COLS);
      lim_y   <= CY_W'(MAX_ROWS);
    end else if (in_fire) begin
      case (in_data.op)
        OP_ADD: begin
          xa  <= CX_W'(in_data.x_start) + CX_W'(1);
          ya  <= CY_W'(in_data.y_start) + CY_W'(1);
          val <= in_data.value;
        end
        OP_BUILD: begin
          xa      <= CX_W'(1);
          xb      <= '0;
          ya      <= CY_W'(1);
          yb      <= '0;
          y_first <= 1'b1;
          lim_x   <= w_eff;
          lim_y   <= h_eff;
        end
        OP_QUERY: begin
          xa <= q_xe;
          xb <= q_xs;
          ya <= q_ye;
          yb <= q_ys;
        end
        default: begin
          val <= val;
        end
      endcase
    end else if (step_go && cw.seq == SEQ_LOOP && !loop_end) begin
      if (ya != lim_y) begin
        yb <= ya;
        ya <= ya + CY_W'(1);
      end else begin
        xb <= xa;
        xa <= xa + CX_W'(1);
        ya <= CY_W'(y_first);
        yb <= '0;
      end
    end
  end

  always_comb begin
    unique case (cw.acc)
      ACC_HOLD: acc_next = acc;
      ACC_LOAD: acc_next = rdata;
      ACC_ADD:  acc_next = acc + rdata;
      ACC_SUB:  acc_next = acc - rdata;
      ACC_ADDV: acc_next = rdata + SUM_BITS'(val);
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      acc <= acc_next;
    end
  end

  assign rx = (cw.rsel == SEL_BA || cw.rsel == SEL_BB) ? xb : xa;
  assign ry = (cw.rsel == SEL_AB || cw.rsel == SEL_BB) ? yb : ya;

  assign raddr  = AW'(rx) * AW'(STRIDE) + AW'(ry);
  assign waddr  = AW'(xa) * AW'(STRIDE) + AW'(ya);
  assign wdata  = (cw.wr == WR_ZERO) ? '0 : acc_next;
  assign ram_we = step_go && (cw.wr != WR_NONE);

  sat_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SUM_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cw.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.kind <= cw.kind;
      out_data.sum  <= (cw.kind == KIND_QUERY) ? 32'(acc_next) : '0;
    end
  end

  // Only the clearing pass may write the guard row and column.
  `SAT_ASSERT_IMPL(a_guard_kept, clk, rst, ram_we && cw.wr == WR_ACC, xa != '0 && ya != '0)
  `SAT_ASSERT_IMPL(a_rose_from_emit, clk, rst, $rose(out_valid), $past(cw.seq == SEQ_EMIT))
  `SAT_ASSERT_NEXT(a_emit_posts, clk, rst, emit_go, out_valid)
  `SAT_ASSERT_IMPL(a_busy_after_reset, clk, rst, $past(rst), !in_ready)

endmodule

`default_nettype wire
